### hdl/uid_pkg.sv
`default_nettype none

package uid_pkg;

    // Default operand width of the divider.
    localparam int DEFAULT_DATA_WIDTH = 32;

    // Special-case marks that travel with each operand pair down the pipeline.
    typedef struct packed {
        logic equal;     // dividend equals divisor
        logic zero_div;  // divisor is zero
    } uid_flags_t;

endpackage

`default_nettype wire

### hdl/uid_stage.sv
`default_nettype none

// One restoring-division step: shift in one dividend bit, trial-subtract the
// divisor, keep or restore, and append one quotient bit. Registered, with its
// own valid bit and backpressure.
module uid_stage #(
    parameter int DATA_WIDTH = uid_pkg::DEFAULT_DATA_WIDTH,
    parameter int BIT_INDEX  = DATA_WIDTH - 1
) (
    input  wire                      aclk,
    input  wire                      aresetn,

    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire uid_pkg::uid_flags_t in_flags,
    input  wire  [DATA_WIDTH-1:0]    in_num,
    input  wire  [DATA_WIDTH-1:0]    in_den,
    input  wire  [DATA_WIDTH-1:0]    in_rem,
    input  wire  [DATA_WIDTH-1:0]    in_quo,

    output logic                     out_valid,
    input  wire                      out_ready,
    output uid_pkg::uid_flags_t      out_flags,
    output logic [DATA_WIDTH-1:0]    out_num,
    output logic [DATA_WIDTH-1:0]    out_den,
    output logic [DATA_WIDTH-1:0]    out_rem,
    output logic [DATA_WIDTH-1:0]    out_quo
);

    logic                      valid_reg;
    uid_pkg::uid_flags_t       flags_reg;
    logic [DATA_WIDTH-1:0]     num_reg;
    logic [DATA_WIDTH-1:0]     den_reg;
    logic [DATA_WIDTH-1:0]     rem_reg;
    logic [DATA_WIDTH-1:0]     quo_reg;

    logic [DATA_WIDTH-1:0]     rem_next;
    logic [DATA_WIDTH-1:0]     quo_next;

    logic [DATA_WIDTH:0]       shifted;
    logic [DATA_WIDTH+1:0]     diff;
    logic                      take;

    // Advance when empty or when the next stage takes our transaction.
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        shifted  = {in_rem, in_num[BIT_INDEX]};
        diff     = {1'b0, shifted} - {2'b00, in_den};
        take     = !diff[DATA_WIDTH+1];
        rem_next = take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        quo_next = {in_quo[DATA_WIDTH-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            flags_reg <= in_flags;
            num_reg   <= in_num;
            den_reg   <= in_den;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_flags = flags_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule

`default_nettype wire

### hdl/unsigned_integer_divider_core.sv
// Pipeline: one capture stage, one stage per quotient bit, one output
//   register, between input transaction and result.
// Throughput: one division per cycle while the downstream side keeps taking
//   results; each stage holds one transaction and passes it on as soon as the stage after it has room.
// Reset: aresetn is synchronous, active low, and empties every stage; the
//   divider keeps no other state.
`default_nettype none

module unsigned_integer_divider_core #(
    parameter int DATA_WIDTH = uid_pkg::DEFAULT_DATA_WIDTH,
    localparam int S_TDATA_WIDTH = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  wire                          aclk,
    input  wire                          aresetn,

    input  wire                          s_tvalid,
    output logic                         s_tready,
    // Fields from bit 0 up: dividend, divisor, zero padding to whole bytes.
    input  wire  [S_TDATA_WIDTH-1:0]     s_tdata,

    output logic                         m_tvalid,
    input  wire                          m_tready,
    // Fields from bit 0 up: quotient, zero padding to whole bytes.
    output logic [M_TDATA_WIDTH-1:0]     m_tdata,
    // Fields from bit 0 up: divide_by_zero.
    output logic                         m_tuser
);

    // ------------------------------------------------------------------
    // Capture stage: register the operands and decide the special cases
    // (equal operands, zero divisor) up front so they ride along.
    // ------------------------------------------------------------------
    logic                      cap_valid_reg;
    uid_pkg::uid_flags_t       cap_flags_reg;
    uid_pkg::uid_flags_t       cap_flags_next;
    logic [DATA_WIDTH-1:0]     cap_num_reg;
    logic [DATA_WIDTH-1:0]     cap_den_reg;

    logic [DATA_WIDTH-1:0]     in_dividend;
    logic [DATA_WIDTH-1:0]     in_divisor;

    // Ready of each division stage's input, and the stage chain payload.
    // Index j is the input of stage j; index DATA_WIDTH is the last output.
    logic                      st_valid [0:DATA_WIDTH];
    logic                      st_ready [0:DATA_WIDTH];
    uid_pkg::uid_flags_t       st_flags [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]     st_num   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]     st_den   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]     st_rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]     st_quo   [0:DATA_WIDTH];

    assign in_dividend = s_tdata[DATA_WIDTH-1:0];
    assign in_divisor  = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    always_comb begin
        cap_flags_next.equal    = (in_dividend == in_divisor);
        cap_flags_next.zero_div = (in_divisor == '0);
    end

    // Take a new transaction whenever the capture stage is empty or drains.
    assign s_tready = !cap_valid_reg || st_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_valid_reg <= 1'b0;
        end else if (s_tready) begin
            cap_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            cap_flags_reg <= cap_flags_next;
            cap_num_reg   <= in_dividend;
            cap_den_reg   <= in_divisor;
        end
    end

    // Partial remainder and quotient start at zero.
    assign st_valid[0] = cap_valid_reg;
    assign st_flags[0] = cap_flags_reg;
    assign st_num[0]   = cap_num_reg;
    assign st_den[0]   = cap_den_reg;
    assign st_rem[0]   = '0;
    assign st_quo[0]   = '0;

    // ------------------------------------------------------------------
    // Division array: stage j resolves quotient bit DATA_WIDTH-1-j, MSB
    // first, with one DATA_WIDTH+1 bit trial subtraction per stage.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < DATA_WIDTH; j++) begin : g_stage
        uid_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .BIT_INDEX  (DATA_WIDTH - 1 - j)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[j]),
            .in_ready  (st_ready[j]),
            .in_flags  (st_flags[j]),
            .in_num    (st_num[j]),
            .in_den    (st_den[j]),
            .in_rem    (st_rem[j]),
            .in_quo    (st_quo[j]),
            .out_valid (st_valid[j+1]),
            .out_ready (st_ready[j+1]),
            .out_flags (st_flags[j+1]),
            .out_num   (st_num[j+1]),
            .out_den   (st_den[j+1]),
            .out_rem   (st_rem[j+1]),
            .out_quo   (st_quo[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register: apply the special cases and hold the result until
    // the downstream side takes it. Stages behind it keep filling.
    // ------------------------------------------------------------------
    logic                      out_valid_reg;
    logic [DATA_WIDTH-1:0]     out_quo_reg;
    logic [DATA_WIDTH-1:0]     out_quo_next;
    logic                      out_dz_reg;

    assign st_ready[DATA_WIDTH] = !out_valid_reg || m_tready;

    always_comb begin
        if (st_flags[DATA_WIDTH].equal) begin
            out_quo_next = DATA_WIDTH'(1);          // equal operands, 0/0 too
        end else if (st_flags[DATA_WIDTH].zero_div) begin
            out_quo_next = '0;                      // nonzero over zero
        end else begin
            out_quo_next = st_quo[DATA_WIDTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (st_ready[DATA_WIDTH]) begin
            out_valid_reg <= st_valid[DATA_WIDTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_ready[DATA_WIDTH]) begin
            out_quo_reg <= out_quo_next;
            out_dz_reg  <= st_flags[DATA_WIDTH].zero_div;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_WIDTH'(out_quo_reg);
    assign m_tuser  = out_dz_reg;

`ifndef SYNTH
    // The zero-divisor mark must stay aligned with the divisor it came from.
    a_flag_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid[DATA_WIDTH] |->
            (st_flags[DATA_WIDTH].zero_div == (st_den[DATA_WIDTH] == '0)))
        else $error("zero-divisor mark out of step with divisor");

    // Restoring division leaves a remainder below the divisor.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid[DATA_WIDTH] && !st_flags[DATA_WIDTH].zero_div) |->
            (st_rem[DATA_WIDTH] < st_den[DATA_WIDTH]))
        else $error("final remainder not below divisor");

    // Equal nonzero operands must divide to one without the override.
    a_equal_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid[DATA_WIDTH] && st_flags[DATA_WIDTH].equal &&
         !st_flags[DATA_WIDTH].zero_div) |->
            (st_quo[DATA_WIDTH] == DATA_WIDTH'(1)))
        else $error("array quotient for equal operands is not one");

    // A zero divisor yields only zero or one.
    a_dz_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (out_quo_reg <= DATA_WIDTH'(1)))
        else $error("divide-by-zero result out of range");
`endif

endmodule

`default_nettype wire
